// ----- rtl/ptpd_pkg.sv -----
// ----------------------------------------------------------------------------
// ptpd_pkg: shared types and constants of the predictor decoder
// Register indexes, mode and error codes, the queue entry and the Paeth pick.
// ----------------------------------------------------------------------------
package ptpd_pkg;

  localparam int unsigned MAX_ROW_BYTES_DEF   = 4096;
  localparam int unsigned MAX_PIXEL_BYTES_DEF = 8;

  // queue entry fields sized for the widest legal parameter values
  localparam int unsigned IDX_FIELD_W = 16;
  localparam int unsigned PBI_FIELD_W = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd3;

  localparam logic [3:0] MODE_PASS_MAX = 4'd1;
  localparam logic [3:0] MODE_TIFF     = 4'd2;
  localparam logic [3:0] MODE_PNG_LO   = 4'd10;
  localparam logic [3:0] MODE_PNG_HI   = 4'd15;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_PRED  = 3'd1;
  localparam logic [2:0] ERR_ROW   = 3'd2;
  localparam logic [2:0] ERR_FILT  = 3'd3;
  localparam logic [2:0] ERR_LIMIT = 3'd4;

  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_SUB   = 3'd1;
  localparam logic [2:0] FLT_UP    = 3'd2;
  localparam logic [2:0] FLT_AVG   = 3'd3;
  localparam logic [2:0] FLT_PAETH = 3'd4;

  // K_END: stream end after an error, clears the histories, no result
  typedef enum logic [1:0] {
    K_PASS,
    K_TIFF,
    K_PNG,
    K_END
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic [7:0]             data;
    logic                   last;
    logic [2:0]             err;
    logic [2:0]             filt;
    logic [IDX_FIELD_W-1:0] idx;
    logic                   use_left;
    logic                   first_row;
    logic [PBI_FIELD_W-1:0] pbi;
  } item_t;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] p;
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
    da = p - $signed({3'b000, a});
    db = p - $signed({3'b000, b});
    dc = p - $signed({3'b000, c});
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    return (db <= dc) ? b : c;
  endfunction

endpackage

// ----- rtl/ptpd_if.sv -----
// ----------------------------------------------------------------------------
// ptpd channel interfaces
// Byte input, result output and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface ptpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ptpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic [2:0] error_code;
  modport source (output valid, output out_byte, output out_last, output error_code,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input error_code,
                  output ready);
endinterface

interface ptpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [31:0] reg_data;
  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// ----- rtl/ptpd_fifo.sv -----
// ----------------------------------------------------------------------------
// ptpd_fifo: two-entry request queue between front and back
// Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module ptpd_fifo
  import ptpd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t din_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t dout_o,
  output logic  valid_o
);

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= din_i;
  end

endmodule

// ----- rtl/ptpd_front.sv -----
// ----------------------------------------------------------------------------
// ptpd_front: register file, row tracking and request classification
// Decides per byte: no result, a decode request, or an error result.
// ----------------------------------------------------------------------------
module ptpd_front
  import ptpd_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int unsigned MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ptpd_in_if.sink  in_i,
  ptpd_cfg_if.sink cfg_i,
  input  logic  q_full_i,
  output logic  q_push_o,
  output item_t q_item_o
);

  localparam int unsigned CW  = $clog2(MAX_ROW_BYTES + 2);
  localparam int unsigned PBW = $clog2(MAX_PIXEL_BYTES + 1);

  logic [3:0]  mode_q, pix_q;
  logic [12:0] row_q;
  logic [31:0] limit_q;

  logic [CW-1:0] col_q, col_d;
  logic [2:0]    flt_q, flt_d;
  logic          first_q, first_d;
  logic [31:0]   cnt_q, cnt_d;
  logic          fail_q, fail_d;

  logic [CW-1:0]  rl_eff;
  logic [PBW-1:0] pb_eff;
  logic           acc;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !q_full_i;
  assign acc         = in_i.valid && !q_full_i;

  always_comb begin
    if (row_q == 13'd0) rl_eff = CW'(1);
    else if (32'(row_q) > 32'(MAX_ROW_BYTES)) rl_eff = CW'(MAX_ROW_BYTES);
    else rl_eff = CW'(row_q);
    if (pix_q == 4'd0) pb_eff = PBW'(1);
    else if (32'(pix_q) > 32'(MAX_PIXEL_BYTES)) pb_eff = PBW'(MAX_PIXEL_BYTES);
    else pb_eff = PBW'(pix_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PASS_MAX;
      pix_q   <= 4'd1;
      row_q   <= 13'd1;
      limit_q <= '1;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        REG_MODE:  mode_q  <= cfg_i.reg_data[3:0];
        REG_PIXEL: pix_q   <= cfg_i.reg_data[3:0];
        REG_ROW:   row_q   <= cfg_i.reg_data[12:0];
        REG_LIMIT: limit_q <= cfg_i.reg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic          do_emit, do_fail, end_s;
    logic [2:0]    fcode;
    logic [CW-1:0] col, ncol, idx;
    col_d    = col_q;
    flt_d    = flt_q;
    first_d  = first_q;
    cnt_d    = cnt_q;
    fail_d   = fail_q;
    q_push_o = 1'b0;
    do_emit  = 1'b0;
    do_fail  = 1'b0;
    end_s    = 1'b0;
    fcode    = ERR_NONE;
    col      = '0;
    ncol     = '0;
    idx      = '0;
    q_item_o.kind      = K_PASS;
    q_item_o.data      = in_i.in_byte;
    q_item_o.last      = in_i.in_last;
    q_item_o.err       = ERR_NONE;
    q_item_o.filt      = flt_q;
    q_item_o.idx       = '0;
    q_item_o.use_left  = 1'b0;
    q_item_o.first_row = first_q;
    q_item_o.pbi       = PBI_FIELD_W'(pb_eff - PBW'(1));
    if (acc) begin
      if (fail_q) begin
        end_s = in_i.in_last;
        // back side still has to clear its histories at the stream end
        if (in_i.in_last) begin
          q_push_o      = 1'b1;
          q_item_o.kind = K_END;
        end
      end else if (mode_q <= MODE_PASS_MAX) begin
        do_emit = 1'b1;
      end else if (mode_q != MODE_TIFF && (mode_q < MODE_PNG_LO || mode_q > MODE_PNG_HI)) begin
        do_fail = 1'b1;
        fcode   = ERR_PRED;
      end else if (mode_q == MODE_TIFF) begin
        col = (col_q >= rl_eff) ? '0 : col_q;
        q_item_o.kind     = K_TIFF;
        q_item_o.use_left = (32'(col) >= 32'(pb_eff));
        ncol = col + CW'(1);
        if (ncol == rl_eff) ncol = '0;
        col_d = ncol;
        if (in_i.in_last && ncol != '0) begin
          do_fail = 1'b1;
          fcode   = ERR_ROW;
        end else begin
          do_emit = 1'b1;
        end
      end else begin
        col = (col_q > rl_eff) ? '0 : col_q;
        if (col == '0) begin
          col_d = '0;
          if (in_i.in_last) begin
            do_fail = 1'b1;
            fcode   = ERR_ROW;
          end else if (in_i.in_byte > 8'(FLT_PAETH)) begin
            do_fail = 1'b1;
            fcode   = ERR_FILT;
          end else begin
            flt_d = in_i.in_byte[2:0];
            col_d = CW'(1);
          end
        end else begin
          idx = col - CW'(1);
          q_item_o.kind     = K_PNG;
          q_item_o.idx      = IDX_FIELD_W'(idx);
          q_item_o.use_left = (32'(idx) >= 32'(pb_eff));
          ncol = col + CW'(1);
          if (ncol > rl_eff) begin
            ncol    = '0;
            first_d = 1'b0;
          end
          col_d = ncol;
          if (in_i.in_last && ncol != '0) begin
            do_fail = 1'b1;
            fcode   = ERR_ROW;
          end else begin
            do_emit = 1'b1;
          end
        end
      end
      if (do_emit) begin
        if (cnt_q >= limit_q) begin
          do_fail = 1'b1;
          fcode   = ERR_LIMIT;
        end else begin
          cnt_d    = cnt_q + 32'd1;
          q_push_o = 1'b1;
          end_s    = in_i.in_last;
        end
      end
      if (do_fail) begin
        q_push_o     = 1'b1;
        q_item_o.err = fcode;
        if (in_i.in_last) end_s = 1'b1;
        else fail_d = 1'b1;
      end
      if (end_s) begin
        col_d   = '0;
        flt_d   = FLT_NONE;
        first_d = 1'b1;
        cnt_d   = '0;
        fail_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      flt_q   <= FLT_NONE;
      first_q <= 1'b1;
      cnt_q   <= '0;
      fail_q  <= 1'b0;
    end else begin
      col_q   <= col_d;
      flt_q   <= flt_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
      fail_q  <= fail_d;
    end
  end

endmodule

// ----- rtl/ptpd_back.sv -----
// ----------------------------------------------------------------------------
// ptpd_back: line store, pixel histories, unfilter arithmetic, output register
// Line store is read when a request leaves the queue; same-address write forwards.
// ----------------------------------------------------------------------------
module ptpd_back
  import ptpd_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int unsigned MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_valid_i,
  input  item_t q_item_i,
  output logic  q_pop_o,
  ptpd_out_if.source out_o
);

  localparam int unsigned AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int unsigned PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [7:0] line_mem [MAX_ROW_BYTES];
  logic [7:0] lh_q [MAX_PIXEL_BYTES];
  logic [7:0] ulh_q [MAX_PIXEL_BYTES];

  item_t      a_q;
  logic       a_vld_q;
  logic [7:0] rd_q;
  logic       o_vld_q, o_last_q;
  logic [7:0] o_byte_q;
  logic [2:0] o_err_q;

  logic       a_adv, a_load, we, a_res;
  logic [7:0] left, above, ul, pred, v;
  logic [8:0] avg_sum;

  assign a_adv   = a_vld_q && (!o_vld_q || out_o.ready);
  assign a_load  = q_valid_i && (!a_vld_q || a_adv);
  assign q_pop_o = a_load;
  assign we      = a_adv && (a_q.kind == K_PNG);
  assign a_res   = a_adv && (a_q.kind != K_END);

  always_comb begin
    left    = a_q.use_left ? lh_q[a_q.pbi[PW-1:0]] : 8'd0;
    above   = a_q.first_row ? 8'd0 : rd_q;
    ul      = (!a_q.first_row && a_q.use_left) ? ulh_q[a_q.pbi[PW-1:0]] : 8'd0;
    avg_sum = 9'(left) + 9'(above);
    case (a_q.filt)
      FLT_SUB:   pred = left;
      FLT_UP:    pred = above;
      FLT_AVG:   pred = avg_sum[8:1];
      FLT_PAETH: pred = paeth_pick(left, above, ul);
      default:   pred = 8'd0;
    endcase
    case (a_q.kind)
      K_TIFF:  v = a_q.data + left;
      K_PNG:   v = a_q.data + pred;
      default: v = a_q.data;
    endcase
  end

  // line store with write-first forwarding on the read port
  always_ff @(posedge clk_i) begin
    if (we) line_mem[a_q.idx[AW-1:0]] <= v;
    if (a_load) begin
      if (we && a_q.idx[AW-1:0] == q_item_i.idx[AW-1:0]) rd_q <= v;
      else rd_q <= line_mem[q_item_i.idx[AW-1:0]];
    end
  end

  // histories: left shifts per TIFF/PNG byte, upper-left per PNG byte; clear at every stream end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        lh_q[k]  <= 8'd0;
        ulh_q[k] <= 8'd0;
      end
    end else if (a_adv && a_q.last) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        lh_q[k]  <= 8'd0;
        ulh_q[k] <= 8'd0;
      end
    end else begin
      if (a_adv && (a_q.kind == K_TIFF || a_q.kind == K_PNG)) begin
        lh_q[0] <= v;
        for (int k = 1; k < MAX_PIXEL_BYTES; k++) lh_q[k] <= lh_q[k-1];
      end
      if (we) begin
        ulh_q[0] <= above;
        for (int k = 1; k < MAX_PIXEL_BYTES; k++) ulh_q[k] <= ulh_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) a_q <= q_item_i;
    if (a_res) begin
      o_byte_q <= (a_q.err != ERR_NONE) ? 8'd0 : v;
      o_last_q <= (a_q.err != ERR_NONE) ? 1'b1 : a_q.last;
      o_err_q  <= a_q.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (a_load) a_vld_q <= 1'b1;
      else if (a_adv) a_vld_q <= 1'b0;
      if (a_res) o_vld_q <= 1'b1;
      else if (out_o.ready) o_vld_q <= 1'b0;
    end
  end

  assign out_o.valid      = o_vld_q;
  assign out_o.out_byte   = o_byte_q;
  assign out_o.out_last   = o_last_q;
  assign out_o.error_code = o_err_q;

endmodule

// ----- rtl/png_tiff_predictor_decoder.sv -----
// ----------------------------------------------------------------------------
// png_tiff_predictor_decoder: PDF predictor decoder (PNG unfilter and TIFF)
// Byte-serial undo of PDF predictors with a row line store and Paeth.
// ----------------------------------------------------------------------------
// Usage:
//  in_i carries one stream byte per request (in_byte, in_last marks the end).
//  out_o carries zero or one result per byte: out_byte, out_last, error_code.
//  cfg_i writes registers 0..3: predictor_mode, pixel_bytes, row_length,
//  output_limit; always ready, write only when the block is drained.
//  Throughput: one byte per cycle sustained while the receiver is ready; the
//  Paeth pick plus the line-store read register set the decode step.
//  Path from byte accept to result valid: queue entry, then decode stage
//  into the output register; classify is combinational.
//  PNG filter bytes and bytes after an error give no result.
//  Stall: a stalled receiver holds the output register; the decode stage and
//  a two-entry queue then fill, after which in_i.ready drops.
//  Reset: registers return to mode 1, 1 byte/pixel, row 1, unlimited output;
//  stream state is cleared. The line store is not cleared: a fresh stream
//  writes each row entry before the next row reads it.
module png_tiff_predictor_decoder
  import ptpd_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int unsigned MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  ptpd_in_if.sink     in_i,
  ptpd_out_if.source  out_o,
  ptpd_cfg_if.sink    cfg_i
);

  logic  q_push, q_full, q_pop, q_valid;
  item_t q_in, q_out;

  // front: classify bytes, track rows, count output
  ptpd_front #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg_i),
    .q_full_i(q_full),
    .q_push_o(q_push),
    .q_item_o(q_in)
  );

  // decouples the two sides
  ptpd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .din_i  (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .dout_o (q_out),
    .valid_o(q_valid)
  );

  // back: decode arithmetic and result register
  ptpd_back #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_item_i (q_out),
    .q_pop_o  (q_pop),
    .out_o    (out_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("queue push while full");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.error_code != ERR_NONE) |-> out_o.out_last)
    else $error("error result not marked last");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.error_code != ERR_NONE) |-> (out_o.out_byte == 8'd0))
    else $error("error result carries data");
`endif

endmodule

// ----- bench/png_tiff_predictor_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// png_tiff_predictor_decoder_tb: self-checking bench of the predictor decoder
// Feeds passthrough, TIFF and PNG streams through the byte channel. It
// decodes every accepted request in a local model and checks each result
// in order. Register writes are made only while the block is drained.
// ----------------------------------------------------------------------------
module png_tiff_predictor_decoder_tb;
  import ptpd_pkg::*;

  localparam int unsigned ROW_CAP   = 4096;
  localparam int unsigned PIX_CAP   = 8;
  localparam int unsigned QUIET_CYC = 10;   // keep margin over the block's request path
  localparam int unsigned LONG_HOLD = 400;  // receiver hold-off, in cycles
  localparam int unsigned ITEMS_TOTAL = 950;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_CFG,
    OP_DRAIN
  } op_e;

  typedef struct {
    op_e         op;
    logic [7:0]  b;
    logic        l;
    logic [2:0]  idx;
    logic [31:0] d;
    bit          calm;   // no sender gap before this request
  } pend_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic [2:0] err;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ptpd_in_if  in_ch ();
  ptpd_out_if out_ch ();
  ptpd_cfg_if cfg_ch ();

  png_tiff_predictor_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pend_t   pend_q[$];
  result_t decoded_q[$];   // decoded bytes still due from the block
  int unsigned n_fail = 0;
  int unsigned n_results = 0;
  int unsigned n_items = 0;

  // --------------------------------------------------------------------------
  // Local decoder: register copies and stream state
  // --------------------------------------------------------------------------
  logic [3:0]  m_mode = 4'd1;
  logic [3:0]  m_pix = 4'd1;
  logic [12:0] m_row = 13'd1;
  logic [31:0] m_limit = 32'hFFFF_FFFF;
  logic [7:0]  m_prior [ROW_CAP];
  logic [7:0]  m_left [PIX_CAP];
  logic [7:0]  m_upleft [PIX_CAP];
  int unsigned m_col = 0;
  logic [2:0]  m_filt = FLT_NONE;
  bit          m_first = 1'b1;
  logic [31:0] m_count = '0;
  bit          m_failed = 1'b0;

  function automatic int unsigned eff_pix(input logic [3:0] p);
    if (p == 0) return 1;
    if (p > PIX_CAP) return PIX_CAP;
    return p;
  endfunction

  function automatic int unsigned eff_row(input logic [12:0] r);
    if (r == 0) return 1;
    if (r > ROW_CAP) return ROW_CAP;
    return r;
  endfunction

  function automatic logic [7:0] paeth_of(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
    int est, da, db, dc;
    est = int'(a) + int'(b) - int'(c);
    da = est - int'(a);
    db = est - int'(b);
    dc = est - int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    return (db <= dc) ? b : c;
  endfunction

  task automatic stream_done();
    m_col = 0;
    m_filt = FLT_NONE;
    m_first = 1'b1;
    m_count = '0;
    m_failed = 1'b0;
    foreach (m_left[k]) begin
      m_left[k] = '0;
      m_upleft[k] = '0;
    end
  endtask

  task automatic push_hist(inout logic [7:0] h [PIX_CAP], input logic [7:0] v);
    for (int k = PIX_CAP - 1; k > 0; k--) h[k] = h[k-1];
    h[0] = v;
  endtask

  // error result ends the stream output; state clears at in_last
  task automatic expect_error(input logic [2:0] code, input logic lst);
    result_t r;
    r.data = '0;
    r.last = 1'b1;
    r.err = code;
    decoded_q = {decoded_q, r};
    if (lst) stream_done();
    else m_failed = 1'b1;
  endtask

  task automatic expect_byte(input logic [7:0] v, input logic lst);
    result_t r;
    if (m_count >= m_limit) begin
      expect_error(ERR_LIMIT, lst);
      return;
    end
    m_count++;
    r.data = v;
    r.last = lst;
    r.err = ERR_NONE;
    decoded_q = {decoded_q, r};
    if (lst) stream_done();
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic lst);
    int unsigned pb, rl, i;
    logic [7:0] lf, ab, ul, v;
    if (m_failed) begin
      if (lst) stream_done();
      return;
    end
    if (m_mode <= MODE_PASS_MAX) begin
      expect_byte(b, lst);
      return;
    end
    if (m_mode != MODE_TIFF && (m_mode < MODE_PNG_LO || m_mode > MODE_PNG_HI)) begin
      expect_error(ERR_PRED, lst);
      return;
    end
    pb = eff_pix(m_pix);
    rl = eff_row(m_row);
    if (m_mode == MODE_TIFF) begin
      if (m_col >= rl) m_col = 0;
      i = m_col;
      lf = (i >= pb) ? m_left[pb-1] : 8'd0;
      v = b + lf;
      push_hist(m_left, v);
      m_col++;
      if (m_col == rl) m_col = 0;
      if (lst && m_col != 0) expect_error(ERR_ROW, lst);
      else expect_byte(v, lst);
      return;
    end
    // PNG: column 0 is the filter byte of the row
    if (m_col > rl) m_col = 0;
    if (m_col == 0) begin
      if (lst) expect_error(ERR_ROW, lst);
      else if (b > 8'(FLT_PAETH)) expect_error(ERR_FILT, lst);
      else begin
        m_filt = b[2:0];
        m_col = 1;
      end
      return;
    end
    i = m_col - 1;
    ab = m_first ? 8'd0 : m_prior[i];
    lf = (i >= pb) ? m_left[pb-1] : 8'd0;
    ul = (!m_first && i >= pb) ? m_upleft[pb-1] : 8'd0;
    case (m_filt)
      FLT_SUB:   v = b + lf;
      FLT_UP:    v = b + ab;
      FLT_AVG:   v = b + 8'((9'(lf) + 9'(ab)) >> 1);
      FLT_PAETH: v = b + paeth_of(lf, ab, ul);
      default:   v = b;
    endcase
    push_hist(m_left, v);
    push_hist(m_upleft, ab);
    m_prior[i] = v;
    m_col++;
    if (m_col > rl) begin
      m_col = 0;
      m_first = 1'b0;
    end
    if (lst && m_col != 0) expect_error(ERR_ROW, lst);
    else expect_byte(v, lst);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
    case (idx)
      REG_MODE:  m_mode = d[3:0];
      REG_PIXEL: m_pix = d[3:0];
      REG_ROW:   m_row = d[12:0];
      REG_LIMIT: m_limit = d;
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] b, input logic l, input bit calm = 1'b0);
    pend_t p;
    p.op = OP_BYTE;
    p.b = b;
    p.l = l;
    p.idx = '0;
    p.d = '0;
    p.calm = calm;
    pend_q = {pend_q, p};
    n_items++;
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [31:0] d);
    pend_t p;
    p.op = OP_CFG;
    p.b = '0;
    p.l = 1'b0;
    p.idx = idx;
    p.d = d;
    p.calm = 1'b0;
    pend_q = {pend_q, p};
  endtask

  task automatic add_drain();
    pend_t p;
    p.op = OP_DRAIN;
    p.b = '0;
    p.l = 1'b0;
    p.idx = '0;
    p.d = '0;
    p.calm = 1'b0;
    pend_q = {pend_q, p};
  endtask

  task automatic setup(input logic [3:0] md, input logic [3:0] pb, input logic [12:0] rl,
                       input logic [31:0] lim);
    add_cfg(REG_MODE, {28'd0, md});
    add_cfg(REG_PIXEL, {28'd0, pb});
    add_cfg(REG_ROW, {19'd0, rl});
    add_cfg(REG_LIMIT, lim);
  endtask

  // One stream of rows; cut shortens it to a partial last row,
  // bad_filt swaps in an illegal filter byte now and then.
  task automatic add_stream(input bit png, input int unsigned rl, input int unsigned rows,
                            input bit cut, input bit bad_filt, input bit calm);
    logic [7:0] bytes[$];
    int unsigned n;
    for (int r = 0; r < rows; r++) begin
      if (png) begin
        if (bad_filt && $urandom_range(0, 2) == 0) bytes = {bytes, 8'($urandom_range(5, 255))};
        else bytes = {bytes, 8'($urandom_range(0, 4))};
      end
      for (int c = 0; c < rl; c++) bytes = {bytes, 8'($urandom)};
    end
    n = bytes.size();
    if (cut) n = $urandom_range(1, n);
    for (int k = 0; k < n; k++) add_byte(bytes[k], k == n - 1, calm);
  endtask

  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 9);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: byte requests and register writes from pend_q
  // --------------------------------------------------------------------------
  int unsigned gap_left = 0;
  int unsigned quiet = 0;

  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    pend_t hd;
    logic  nv_in, nv_cfg, took;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.in_byte <= '0;
      in_ch.in_last <= 1'b0;
      cfg_ch.valid <= 1'b0;
      cfg_ch.reg_index <= '0;
      cfg_ch.reg_data <= '0;
      gap_left = 0;
      quiet = 0;
    end else begin
      nv_in = in_ch.valid;
      nv_cfg = cfg_ch.valid;
      took = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.in_byte, in_ch.in_last);
        nv_in = 1'b0;
        took = 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        write_reg(cfg_ch.reg_index, cfg_ch.reg_data);
        nv_cfg = 1'b0;
      end
      // a filter byte or an ignored byte gives no result, so count quiet cycles
      if (took || nv_in || decoded_q.size() != 0 || out_ch.valid) quiet = 0;
      else quiet++;
      if (!nv_in && !nv_cfg && pend_q.size() != 0) begin
        hd = pend_q[0];
        if (hd.op == OP_BYTE) begin
          if (gap_left > 0 && !hd.calm) gap_left--;
          else begin
            in_ch.in_byte <= hd.b;
            in_ch.in_last <= hd.l;
            nv_in = 1'b1;
            void'(pend_q.pop_front());
            gap_left = draw_gap();
          end
        end else if (quiet >= QUIET_CYC) begin
          // registers change only with the block drained
          if (hd.op == OP_CFG) begin
            cfg_ch.reg_index <= hd.idx;
            cfg_ch.reg_data <= hd.d;
            nv_cfg = 1'b1;
          end
          void'(pend_q.pop_front());
        end
      end
      in_ch.valid <= nv_in;
      cfg_ch.valid <= nv_cfg;
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off, counted on its own
  // --------------------------------------------------------------------------
  int unsigned hold_left = 0;
  bit          long_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : long_hold
    if (!rst_ni) begin
      hold_left <= 0;
      long_done <= 1'b0;
    end else if (!long_done && n_results >= 100 && out_ch.valid) begin
      // once, mid-stream: stall long enough for the input side to back up
      long_done <= 1'b1;
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random ready and in-order compare
  // --------------------------------------------------------------------------
  int unsigned out_wait = 0;

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    result_t want;
    logic    rdy;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (decoded_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected result: byte %0h last %0b err %0d",
                     out_ch.out_byte, out_ch.out_last, out_ch.error_code);
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_byte !== want.data || out_ch.out_last !== want.last ||
              out_ch.error_code !== want.err) begin
            n_fail++;
            if (n_fail <= 10)
              $display("result %0d: want byte %0h last %0b err %0d, got %0h %0b %0d",
                       n_results, want.data, want.last, want.err,
                       out_ch.out_byte, out_ch.out_last, out_ch.error_code);
          end
        end
        out_wait = draw_gap();
      end
      if (hold_left > 0) begin
        rdy = 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ch.ready <= rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // --------------------------------------------------------------------------
  initial begin : stim
    logic [3:0]  md, pb;
    logic [12:0] rl;
    logic [31:0] lim;
    int unsigned sel, rows;
    bit          png, broken;

    // reset registers: plain passthrough, extremes of the byte
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    // unsupported predictor, following bytes ignored up to in_last
    setup(4'd3, 4'd1, 13'd1, 32'hFFFF_FFFF);
    add_byte(8'h5A, 1'b0);
    add_byte(8'hA5, 1'b1);
    // PNG, every filter over a 2-byte pixel row
    setup(4'd10, 4'd2, 13'd3, 32'hFFFF_FFFF);
    add_byte(8'(FLT_NONE), 1'b0); add_byte(8'h10, 1'b0); add_byte(8'hF0, 1'b0);
    add_byte(8'h33, 1'b0);
    add_byte(8'(FLT_SUB), 1'b0);  add_byte(8'h01, 1'b0); add_byte(8'h02, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'(FLT_UP), 1'b0);   add_byte(8'h80, 1'b0); add_byte(8'h7F, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'(FLT_AVG), 1'b0);  add_byte(8'hFF, 1'b0); add_byte(8'h11, 1'b0);
    add_byte(8'h22, 1'b0);
    add_byte(8'(FLT_PAETH), 1'b0); add_byte(8'h9C, 1'b0); add_byte(8'h01, 1'b0);
    add_byte(8'hEE, 1'b1);
    // filter byte marked last gives a row-length error, even when illegal
    add_byte(8'hFF, 1'b1);
    // illegal filter byte
    add_byte(8'd5, 1'b0);
    add_byte(8'd1, 1'b1);
    // output limit of zero and of two
    setup(4'd0, 4'd0, 13'd0, 32'd0);
    add_byte(8'h42, 1'b1);
    add_cfg(REG_LIMIT, 32'd2);
    add_drain();
    add_stream(1'b0, 5, 1, 1'b0, 1'b0, 1'b0);

    // saturated pixel size in TIFF, long PNG rows deep into the line store
    setup(4'd2, 4'd15, 13'd20, 32'hFFFF_FFFF);
    add_stream(1'b0, 20, 2, 1'b0, 1'b0, 1'b0);
    setup(4'd15, 4'd8, 13'd160, 32'hFFFF_FFFF);
    add_stream(1'b1, 160, 2, 1'b0, 1'b0, 1'b1);

    // random part: mostly well-formed streams at small sizes
    while (n_items < ITEMS_TOTAL) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) md = 4'($urandom_range(10, 15));
      else if (sel < 70) md = 4'd2;
      else if (sel < 85) md = 4'($urandom_range(0, 1));
      else md = 4'($urandom_range(3, 9));
      pb = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(1, 8));
      rl = ($urandom_range(0, 19) == 0) ? 13'd0 : 13'($urandom_range(1, 24));
      sel = $urandom_range(0, 9);
      if (sel < 6) lim = 32'hFFFF_FFFF;
      else if (sel < 8) lim = $urandom_range(0, 40);
      else lim = $urandom;
      setup(md, pb, rl, lim);
      png = (md >= MODE_PNG_LO);
      broken = ($urandom_range(0, 4) == 0);
      rows = $urandom_range(1, 4);
      if (md == MODE_TIFF || png)
        add_stream(png, eff_row(rl), rows, broken, broken, $urandom_range(0, 4) == 0);
      else
        add_stream(1'b0, $urandom_range(1, 40), 1, 1'b0, 1'b0, 1'b0);
      if ($urandom_range(0, 5) == 0) add_drain();
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pend_q.size() != 0 || in_ch.valid || cfg_ch.valid || decoded_q.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_fail == 0 && decoded_q.size() == 0) begin
      $display("png_tiff_predictor_decoder_tb OK");
    end else begin
      $display("png_tiff_predictor_decoder_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("png_tiff_predictor_decoder_tb NOT OK");
    $finish;
  end

endmodule

// ----- png_tiff_predictor_decoder.f -----
rtl/ptpd_pkg.sv
rtl/ptpd_if.sv
rtl/ptpd_fifo.sv
rtl/ptpd_front.sv
rtl/ptpd_back.sv
rtl/png_tiff_predictor_decoder.sv
bench/png_tiff_predictor_decoder_tb.sv
